// File: hdl/ulmf_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic level median filter package
// Shared widths, constants, status codes and types of the level filter.
// ----------------------------------------------------------------------------
package ulmf_pkg;

  // Depth of the window of valid distance readings.
  localparam int WINDOW_SIZE = 5;
  localparam int RANK_W      = $clog2(WINDOW_SIZE + 1);

  localparam int ECHO_W     = 15;
  localparam int DIST_W     = 16;
  localparam int HEIGHT_W   = 16;
  localparam int PERMILLE_W = 10;
  localparam int STATUS_W   = 2;

  // Distance in 0.1 mm is (width * 112394) >> 16.
  localparam int SCALE_W    = 17;
  localparam int PROD_W     = ECHO_W + SCALE_W;
  localparam int SCALE_SHIFT = 16;
  localparam logic [SCALE_W-1:0] DIST_SCALE_MUL = 17'd112394;

  localparam logic [DIST_W-1:0]   DIST_MIN_DMM = 16'd200;
  localparam logic [DIST_W-1:0]   DIST_MAX_DMM = 16'd50000;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd10000;

  localparam logic [PERMILLE_W-1:0] PERMILLE_SCALE = 10'd1000;
  localparam int DIV_PROD_W = HEIGHT_W + PERMILLE_W;
  localparam int DIV_CNT_W  = $clog2(PERMILLE_W + 1);

  localparam logic [STATUS_W-1:0] ST_VALID   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ECHO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // Contents of one window cell.
  typedef struct packed {
    logic              occ;
    logic [DIST_W-1:0] dmm;
  } cell_data_t;

  // Commands from the sequencer to the window.
  typedef struct packed {
    logic insert;
    logic scan;
  } win_ctrl_t;

endpackage

// File: hdl/ulmf_if.sv
// ----------------------------------------------------------------------------
// Ultrasonic level median filter channels
// Valid/ready channels for the echo word and the level result word.
// ----------------------------------------------------------------------------
interface ulmf_in_if import ulmf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_width_us;

  modport source (output valid, output echo_width_us, input ready);
  modport sink   (input valid, input echo_width_us, output ready);
endinterface

interface ulmf_out_if import ulmf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [DIST_W-1:0]     filtered_distance_dmm;
  logic [HEIGHT_W-1:0]   level_dmm;
  logic [PERMILLE_W-1:0] level_permille;

  modport source (output valid, output status, output filtered_distance_dmm,
                  output level_dmm, output level_permille, input ready);
  modport sink   (input valid, input status, input filtered_distance_dmm,
                  input level_dmm, input level_permille, output ready);
endinterface

// File: hdl/ultrasonic_level_median_filter_top.sv
// ----------------------------------------------------------------------------
// Ultrasonic level median filter, top level
// Echo width to distance, median window, tank level and permille output.
// ----------------------------------------------------------------------------
// Each input word carries one echo width in microseconds and yields exactly
// one result word. A width of zero gives status "no echo"; a distance outside
// 20 mm to 5000 mm gives status "out of range"; both leave the window alone
// and report zero distance, level and permille. A valid distance enters a
// row of five cells holding the latest valid readings, and the result carries
// the median of the readings held so far (the upper middle one for an even
// count), the level below the configured tank height and that level in
// thousandths of the height. The block works on one word at a time: a
// rejected echo passes from acceptance through the check state to the
// result register, and a valid one also passes the cell row, which rotates
// once past the comparison point to find the median, and the ten-step
// permille divider. The result register lets the next word in while a
// finished result still waits to be taken. The tank height register resets
// to 1 m and should only be written while no word is in flight.
// ----------------------------------------------------------------------------
module ultrasonic_level_median_filter_top import ulmf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [HEIGHT_W-1:0] cfg_wdata_i,
  ulmf_in_if.sink             in_i,
  ulmf_out_if.source          out_o
);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LEVEL  = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]            state_q;
  logic [HEIGHT_W-1:0]   height_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  zero_q;
  logic [RANK_W-1:0]     scan_cnt_q;
  logic [HEIGHT_W-1:0]   level_q;

  logic [STATUS_W-1:0]   res_status_q;
  logic [DIST_W-1:0]     res_dist_q;
  logic [HEIGHT_W-1:0]   res_level_q;
  logic [PERMILLE_W-1:0] res_perm_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [DIST_W-1:0]     out_dist_q;
  logic [HEIGHT_W-1:0]   out_level_q;
  logic [PERMILLE_W-1:0] out_perm_q;

  logic                  in_fire;
  logic                  out_fire;
  logic                  out_load;
  logic [DIST_W-1:0]     dist_dmm;
  logic                  dist_ok;
  win_ctrl_t             win_ctrl;
  logic [DIST_W-1:0]     median;
  logic                  div_start;
  logic                  div_done;
  logic [PERMILLE_W-1:0] div_quot;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // The scaled product is registered on acceptance; its upper half is the
  // distance in 0.1 mm.
  assign dist_dmm = prod_q[SCALE_SHIFT +: DIST_W];
  assign dist_ok  = (dist_dmm >= DIST_MIN_DMM) && (dist_dmm <= DIST_MAX_DMM);

  assign win_ctrl.insert = (state_q == S_CHECK) && !zero_q && dist_ok;
  assign win_ctrl.scan   = (state_q == S_SCAN);
  assign div_start       = (state_q == S_DSTART);

  ulmf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .dist_i   (dist_dmm),
    .median_o (median)
  );

  ulmf_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .level_i  (level_q),
    .height_i (height_q),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  // Tank height register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      height_q <= cfg_wdata_i;
    end
  end

  // Sequencer. The window is only touched by a valid distance; the rotation
  // during the scan takes exactly WINDOW_SIZE steps, so the row ends up in
  // its original order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_cnt_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          scan_cnt_q <= '0;
          if (zero_q || !dist_ok) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt_q <= scan_cnt_q + 1'b1;
          if (scan_cnt_q == RANK_W'(WINDOW_SIZE - 1)) begin
            state_q <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the word in flight.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prod_q <= PROD_W'(in_i.echo_width_us) * PROD_W'(DIST_SCALE_MUL);
      zero_q <= (in_i.echo_width_us == '0);
    end
    if (state_q == S_CHECK) begin
      res_dist_q  <= '0;
      res_level_q <= '0;
      res_perm_q  <= '0;
      if (zero_q) begin
        res_status_q <= ST_NO_ECHO;
      end else if (!dist_ok) begin
        res_status_q <= ST_RANGE;
      end else begin
        res_status_q <= ST_VALID;
      end
    end
    if (state_q == S_LEVEL) begin
      // Level is clamped at zero when the surface reads below the bottom.
      level_q <= (height_q > median) ? (height_q - median) : '0;
    end
    if ((state_q == S_DWAIT) && div_done) begin
      res_dist_q  <= median;
      res_level_q <= level_q;
      res_perm_q  <= (height_q == '0) ? '0 : div_quot;
    end
  end

  // Result register towards the output channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_dist_q   <= res_dist_q;
      out_level_q  <= res_level_q;
      out_perm_q   <= res_perm_q;
    end
  end

  assign out_o.valid                 = out_valid_q;
  assign out_o.status                = out_status_q;
  assign out_o.filtered_distance_dmm = out_dist_q;
  assign out_o.level_dmm             = out_level_q;
  assign out_o.level_permille        = out_perm_q;

  // A valid result always carries a median that passed the range check.
  a_valid_dist_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_VALID)) |->
      ((out_dist_q >= DIST_MIN_DMM) && (out_dist_q <= DIST_MAX_DMM)))
    else $error("valid result with a distance outside the accepted range");

  // Rejected readings report zero in every numeric field.
  a_reject_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_VALID)) |->
      ((out_dist_q == '0) && (out_level_q == '0) && (out_perm_q == '0)))
    else $error("rejected reading with non-zero result fields");

  // The divider result never passes a full tank.
  a_permille_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_perm_q <= PERMILLE_SCALE))
    else $error("permille result above one thousand");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DWAIT))
    else $error("divider finished outside its wait state");

endmodule

// File: hdl/ulmf_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one distance reading, takes its neighbour's reading on a step and
// compares its own reading with the broadcast candidate.
// ----------------------------------------------------------------------------
module ulmf_cell import ulmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cell_data_t        d_i,
  input  logic [DIST_W-1:0] cand_i,
  output cell_data_t        q_o,
  output logic              lt_o,
  output logic              eq_o
);

  logic              occ_q;
  logic [DIST_W-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (step_i) begin
      occ_q <= d_i.occ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      dist_q <= d_i.dmm;
    end
  end

  assign q_o.occ  = occ_q;
  assign q_o.dmm  = dist_q;
  assign lt_o     = occ_q && (dist_q < cand_i);
  assign eq_o     = occ_q && (dist_q == cand_i);

endmodule

// File: hdl/ulmf_window.sv
// ----------------------------------------------------------------------------
// Reading window
// A row of cells holding the last valid readings, and the rank logic that
// picks the median while the row rotates once past the candidate position.
// ----------------------------------------------------------------------------
module ulmf_window import ulmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  win_ctrl_t         ctrl_i,
  input  logic [DIST_W-1:0] dist_i,
  output logic [DIST_W-1:0] median_o
);

  cell_data_t        cell_q  [WINDOW_SIZE];
  cell_data_t        cell_in [WINDOW_SIZE];
  logic              lt      [WINDOW_SIZE];
  logic              eq      [WINDOW_SIZE];
  cell_data_t        cand;
  logic              step;
  logic [RANK_W-1:0] n_occ;
  logic [RANK_W-1:0] n_lt;
  logic [RANK_W-1:0] n_eq;
  logic [RANK_W-1:0] k_mid;
  logic [RANK_W-1:0] n_le;
  logic              hit;
  logic [DIST_W-1:0] median_q;

  assign step = ctrl_i.insert || ctrl_i.scan;
  assign cand = cell_q[WINDOW_SIZE-1];

  for (genvar j = 0; j < WINDOW_SIZE; j++) begin : g_cell
    if (j == 0) begin : g_head
      // A new reading pushes the oldest one out of the far end; a scan
      // step closes the row into a ring.
      always_comb begin
        if (ctrl_i.insert) begin
          cell_in[j].occ = 1'b1;
          cell_in[j].dmm = dist_i;
        end else begin
          cell_in[j] = cell_q[WINDOW_SIZE-1];
        end
      end
    end else begin : g_body
      assign cell_in[j] = cell_q[j-1];
    end

    ulmf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .d_i    (cell_in[j]),
      .cand_i (cand.dmm),
      .q_o    (cell_q[j]),
      .lt_o   (lt[j]),
      .eq_o   (eq[j])
    );
  end

  always_comb begin
    n_occ = '0;
    n_lt  = '0;
    n_eq  = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      n_occ = n_occ + RANK_W'(cell_q[i].occ);
      n_lt  = n_lt + RANK_W'(lt[i]);
      n_eq  = n_eq + RANK_W'(eq[i]);
    end
  end

  // The candidate is the median when the middle rank falls inside the run
  // of readings equal to it.
  assign k_mid = n_occ >> 1;
  assign n_le  = RANK_W'(n_lt + n_eq);
  assign hit   = cand.occ && (n_lt <= k_mid) && (k_mid < n_le);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan && hit) begin
      median_q <= cand.dmm;
    end
  end

  assign median_o = median_q;

endmodule

// File: hdl/ulmf_divider.sv
// ----------------------------------------------------------------------------
// Permille divider
// Restoring divider giving floor(level * 1000 / height), one quotient bit a
// cycle. The level never exceeds the height, so ten bits suffice.
// ----------------------------------------------------------------------------
module ulmf_divider import ulmf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [HEIGHT_W-1:0]   level_i,
  input  logic [HEIGHT_W-1:0]   height_i,
  output logic                  done_o,
  output logic [PERMILLE_W-1:0] quot_o
);

  logic [DIV_PROD_W-1:0] prod;
  logic [HEIGHT_W-1:0]   rem_q;
  logic [PERMILLE_W-1:0] low_q;
  logic [PERMILLE_W-1:0] quot_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  run_q;
  logic                  done_q;
  logic [HEIGHT_W:0]     trial;
  logic [HEIGHT_W:0]     diff;
  logic                  ge;

  assign prod  = DIV_PROD_W'(level_i) * DIV_PROD_W'(PERMILLE_SCALE);
  assign trial = {rem_q, low_q[PERMILLE_W-1]};
  assign diff  = trial - {1'b0, height_i};
  assign ge    = trial >= {1'b0, height_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(PERMILLE_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // The top of the product is already below the height.
      rem_q  <= prod[DIV_PROD_W-1 -: HEIGHT_W];
      low_q  <= prod[PERMILLE_W-1:0];
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= ge ? diff[HEIGHT_W-1:0] : trial[HEIGHT_W-1:0];
      low_q  <= {low_q[PERMILLE_W-2:0], 1'b0};
      quot_q <= {quot_q[PERMILLE_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
